/* design/pns_pkg.sv */
// Shared constants and types for the two-nearest palette search.
`default_nettype none
package pns_pkg;

   // Default store depth
   localparam int DEFAULT_MAX_ENTRIES = 256;

   // Field widths
   localparam int CHAN_W   = 8;
   localparam int WEIGHT_W = 11;
   localparam int SQ_W     = 2 * CHAN_W;
   localparam int PROD_W   = SQ_W + WEIGHT_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int FRAC_W   = 10;
   localparam int ERR_W    = 16;
   localparam int WORD_W   = 4 * CHAN_W;
   localparam int SIZE_W   = 9;
   localparam int THR_W    = 8;
   localparam int OUT_IDX_W = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = WEIGHT_W;

   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_RED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_GREEN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_BLUE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_ALPHA  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_USE_ALPHA     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_THRESH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PALETTE_SIZE  = 3'd6;

   // Register reset values (weights in Q1.10)
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RED   = 11'd306;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_GREEN = 11'd601;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_BLUE  = 11'd117;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_ALPHA = 11'd341;
   localparam logic [THR_W-1:0]    RST_ALPHA_THRESH = 8'd15;
   localparam logic [SIZE_W-1:0]   RST_PALETTE_SIZE = 9'd256;

   // Request codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Saturated error value
   localparam logic [ERR_W-1:0] ERR_SAT = 16'hFFFF;

   // Distance pipeline status toward the sequencer
   typedef struct packed {
      logic valid;   // out_err / out_tag hold a finished entry
      logic busy;    // some entry still inside the pipeline
   } dist_stat_type;

endpackage
`default_nettype wire

/* design/pns_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/pns_dist.sv */
// Three-stage weighted squared-distance unit, one palette entry per cycle.
`default_nettype none
module pns_dist #(
   parameter int TAG_W = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [TAG_W-1:0]              in_tag,
   input  wire logic [pns_pkg::WORD_W-1:0]    in_entry,
   input  wire logic [pns_pkg::CHAN_W-1:0]    pix_red,
   input  wire logic [pns_pkg::CHAN_W-1:0]    pix_green,
   input  wire logic [pns_pkg::CHAN_W-1:0]    pix_blue,
   input  wire logic [pns_pkg::CHAN_W-1:0]    pix_alpha,
   input  wire logic [pns_pkg::WEIGHT_W-1:0]  weight_red,
   input  wire logic [pns_pkg::WEIGHT_W-1:0]  weight_green,
   input  wire logic [pns_pkg::WEIGHT_W-1:0]  weight_blue,
   input  wire logic [pns_pkg::WEIGHT_W-1:0]  weight_alpha,
   input  wire logic                          use_alpha,
   output logic      [TAG_W-1:0]              out_tag,
   output logic      [pns_pkg::ERR_W-1:0]     out_err,
   output pns_pkg::dist_stat_type             out_stat
);
   import pns_pkg::*;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] x,
                                               input logic [CHAN_W-1:0] y);
      logic [CHAN_W-1:0] d;
      d = (x > y) ? (x - y) : (y - x);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   // Entry word layout: alpha, red, green, blue from top byte down
   logic [CHAN_W-1:0] ent_b, ent_g, ent_r, ent_a;
   assign ent_b = in_entry[CHAN_W-1:0];
   assign ent_g = in_entry[2*CHAN_W-1:CHAN_W];
   assign ent_r = in_entry[3*CHAN_W-1:2*CHAN_W];
   assign ent_a = in_entry[4*CHAN_W-1:3*CHAN_W];

   // Stage 1: squared differences
   logic              v1_ff, v1_in;
   logic [TAG_W-1:0]  tag1_ff;
   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff, sq_a_ff;
   // Stage 2: weighted terms
   logic              v2_ff, v2_in;
   logic [TAG_W-1:0]  tag2_ff;
   logic [PROD_W-1:0] pr_r_ff, pr_g_ff, pr_b_ff, pr_a_ff;
   // Stage 3: sum, drop fraction, saturate
   logic              v3_ff, v3_in;
   logic [TAG_W-1:0]  tag3_ff;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-FRAC_W-1:0] whole;
   logic [WEIGHT_W-1:0] w_alpha_eff;

   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   assign w_alpha_eff = use_alpha ? weight_alpha : '0;

   always_comb begin
      sum = SUM_W'(pr_r_ff) + SUM_W'(pr_g_ff) + SUM_W'(pr_b_ff) + SUM_W'(pr_a_ff);
      whole = sum[SUM_W-1:FRAC_W];
      if (whole[SUM_W-FRAC_W-1:ERR_W] != '0) begin
         err_in = ERR_SAT;
      end else begin
         err_in = whole[ERR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= in_tag;
      sq_r_ff <= sq_diff(ent_r, pix_red);
      sq_g_ff <= sq_diff(ent_g, pix_green);
      sq_b_ff <= sq_diff(ent_b, pix_blue);
      sq_a_ff <= sq_diff(ent_a, pix_alpha);

      tag2_ff <= tag1_ff;
      pr_r_ff <= PROD_W'(weight_red)   * PROD_W'(sq_r_ff);
      pr_g_ff <= PROD_W'(weight_green) * PROD_W'(sq_g_ff);
      pr_b_ff <= PROD_W'(weight_blue)  * PROD_W'(sq_b_ff);
      pr_a_ff <= PROD_W'(w_alpha_eff)  * PROD_W'(sq_a_ff);

      tag3_ff <= tag2_ff;
      err_ff  <= err_in;
   end

   assign out_tag        = tag3_ff;
   assign out_err        = err_ff;
   assign out_stat.valid = v3_ff;
   assign out_stat.busy  = v1_ff | v2_ff | v3_ff;

endmodule
`default_nettype wire

/* design/palette_two_nearest_search.sv */
// Top level: palette store, scan sequencer and best/second-best tracking.
//
// Usage
//   Request channel (req_*): operation 0 loads one palette entry (B,G,R,A)
//   at req_entry_index; entries at or beyond MAX_ENTRIES are dropped. A load
//   gives no response. Operation 1 queries a pixel and gives exactly one
//   response on the rsp_* channel.
//   Query path: a transparent pixel (alpha at or below the threshold) goes
//   straight to the finish state without a scan. Otherwise the block reads N =
//   min(palette_size, MAX_ENTRIES) entries, one per cycle, through one
//   distance pipeline (RAM read plus three stages); the single RAM read port
//   sets the one-entry-per-cycle pace.
//   req_ready is high only while the sequencer is idle, so queries are
//   handled one at a time; loads go back to back. The response sits in an
//   output register. A stalled receiver does not block loads or the start
//   of the next query; a finished query waits until that register is free.
//   Reset restores the register defaults and clears control state. The
//   palette contents are undefined until loaded; nothing sweeps them.
//   Configuration (csr_*) must be written only while the block is idle;
//   the block itself does not enforce this.
`default_nettype none
module palette_two_nearest_search #(
   parameter int MAX_ENTRIES = pns_pkg::DEFAULT_MAX_ENTRIES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [pns_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pns_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_operation,
   input  wire logic [7:0]                      req_entry_index,
   input  wire logic [pns_pkg::CHAN_W-1:0]      req_red,
   input  wire logic [pns_pkg::CHAN_W-1:0]      req_green,
   input  wire logic [pns_pkg::CHAN_W-1:0]      req_blue,
   input  wire logic [pns_pkg::CHAN_W-1:0]      req_alpha,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [pns_pkg::OUT_IDX_W-1:0]   rsp_best_index,
   output logic      [pns_pkg::OUT_IDX_W-1:0]   rsp_second_index,
   output logic      [pns_pkg::ERR_W-1:0]       rsp_best_error,
   output logic      [pns_pkg::ERR_W-1:0]       rsp_second_error,
   output logic                                 rsp_is_transparent
);
   import pns_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);       // store address
   localparam int CW = $clog2(MAX_ENTRIES + 1);   // scan count, holds MAX_ENTRIES

   // Sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // ---------------- configuration registers ----------------
   logic [WEIGHT_W-1:0] w_red_ff, w_green_ff, w_blue_ff, w_alpha_ff;
   logic                use_alpha_ff;
   logic [THR_W-1:0]    thresh_ff;
   logic [SIZE_W-1:0]   psize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_red_ff     <= RST_WEIGHT_RED;
         w_green_ff   <= RST_WEIGHT_GREEN;
         w_blue_ff    <= RST_WEIGHT_BLUE;
         w_alpha_ff   <= RST_WEIGHT_ALPHA;
         use_alpha_ff <= 1'b0;
         thresh_ff    <= RST_ALPHA_THRESH;
         psize_ff     <= RST_PALETTE_SIZE;
      end else if (csr_we) begin
         case (csr_index)
            REG_WEIGHT_RED:   w_red_ff     <= csr_wdata;
            REG_WEIGHT_GREEN: w_green_ff   <= csr_wdata;
            REG_WEIGHT_BLUE:  w_blue_ff    <= csr_wdata;
            REG_WEIGHT_ALPHA: w_alpha_ff   <= csr_wdata;
            REG_USE_ALPHA:    use_alpha_ff <= csr_wdata[0];
            REG_ALPHA_THRESH: thresh_ff    <= csr_wdata[THR_W-1:0];
            REG_PALETTE_SIZE: psize_ff     <= csr_wdata[SIZE_W-1:0];
            default: ;  // unused index, ignored
         endcase
      end
   end

   // ---------------- sequencer ----------------
   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic [CW-1:0]     scan_count;
   logic              transp_ff, transp_in;
   logic              v0_ff;                 // RAM read data valid this cycle
   logic [AW-1:0]     tag0_ff;
   logic [CHAN_W-1:0] pix_r_ff, pix_g_ff, pix_b_ff, pix_a_ff;

   logic req_fire, is_load, is_query, load_in_range, rd_en, rsp_slot_free, rsp_load;
   logic [AW-1:0] rd_addr;

   // entries scanned: palette_size clipped to the store depth
   always_comb begin
      if (32'(psize_ff) > 32'(MAX_ENTRIES)) begin
         scan_count = CW'(MAX_ENTRIES);
      end else begin
         scan_count = CW'(psize_ff);
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid & req_ready;
   assign is_load       = req_fire & (req_operation == OP_LOAD);
   assign is_query      = req_fire & (req_operation == OP_QUERY);
   assign load_in_range = 32'(req_entry_index) < 32'(MAX_ENTRIES);
   assign rd_en         = (state_ff == ST_SCAN);
   assign rd_addr       = issue_ff[AW-1:0];
   assign rsp_slot_free = ~rsp_valid | rsp_ready;
   assign rsp_load      = (state_ff == ST_FINISH) & rsp_slot_free;

   dist_stat_type     dstat;
   logic [AW-1:0]     dtag;
   logic [ERR_W-1:0]  derr;

   always_comb begin
      state_in  = state_ff;
      issue_in  = issue_ff;
      transp_in = transp_ff;
      case (state_ff)
         ST_IDLE: begin
            issue_in = '0;
            if (is_query) begin
               transp_in = (req_alpha <= thresh_ff);
               if (req_alpha <= thresh_ff || scan_count == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            issue_in = issue_ff + CW'(1);
            if (issue_in == scan_count) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last entry has left the pipeline and been ranked
            if (!v0_ff && !dstat.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         v0_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v0_ff    <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff  <= issue_in;
      transp_ff <= transp_in;
      tag0_ff   <= rd_addr;
      if (is_query) begin
         pix_r_ff <= req_red;
         pix_g_ff <= req_green;
         pix_b_ff <= req_blue;
         pix_a_ff <= req_alpha;
      end
   end

   // ---------------- palette store ----------------
   logic [WORD_W-1:0] ram_rdata;

   pns_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (is_load & load_in_range),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_alpha, req_red, req_green, req_blue}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // ---------------- distance unit ----------------
   pns_dist #(
      .TAG_W (AW)
   ) u_dist (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v0_ff),
      .in_tag       (tag0_ff),
      .in_entry     (ram_rdata),
      .pix_red      (pix_r_ff),
      .pix_green    (pix_g_ff),
      .pix_blue     (pix_b_ff),
      .pix_alpha    (pix_a_ff),
      .weight_red   (w_red_ff),
      .weight_green (w_green_ff),
      .weight_blue  (w_blue_ff),
      .weight_alpha (w_alpha_ff),
      .use_alpha    (use_alpha_ff),
      .out_tag      (dtag),
      .out_err      (derr),
      .out_stat     (dstat)
   );

   // ---------------- best / second-best tracking ----------------
   // Strict less-than keeps the earlier entry on ties. Comparing floored,
   // saturated errors gives the same order as comparing exact Q19.10 sums
   // against stored_error * 1024.
   logic [AW-1:0]    best_idx_ff, second_idx_ff;
   logic [ERR_W-1:0] best_err_ff, second_err_ff;

   always_ff @(posedge clock) begin
      if (is_query) begin
         best_idx_ff   <= '0;
         second_idx_ff <= '0;
         best_err_ff   <= ERR_SAT;
         second_err_ff <= ERR_SAT;
      end else if (dstat.valid) begin
         if (derr < best_err_ff) begin
            second_idx_ff <= best_idx_ff;
            second_err_ff <= best_err_ff;
            best_idx_ff   <= dtag;
            best_err_ff   <= derr;
         end else if (derr < second_err_ff) begin
            second_idx_ff <= dtag;
            second_err_ff <= derr;
         end
      end
   end

   // ---------------- response register ----------------
   logic                 rsp_valid_ff;
   logic [OUT_IDX_W-1:0] rsp_best_idx_ff, rsp_second_idx_ff;
   logic [ERR_W-1:0]     rsp_best_err_ff, rsp_second_err_ff;
   logic                 rsp_transp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_transp_ff <= transp_ff;
         if (transp_ff) begin
            rsp_best_idx_ff   <= '0;
            rsp_second_idx_ff <= '0;
            rsp_best_err_ff   <= ERR_SAT;
            rsp_second_err_ff <= ERR_SAT;
         end else begin
            rsp_best_idx_ff   <= OUT_IDX_W'(best_idx_ff);
            // no second found: report the best entry twice
            rsp_second_idx_ff <= (second_err_ff == ERR_SAT) ? OUT_IDX_W'(best_idx_ff)
                                                            : OUT_IDX_W'(second_idx_ff);
            rsp_best_err_ff   <= best_err_ff;
            rsp_second_err_ff <= second_err_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_best_index     = rsp_best_idx_ff;
   assign rsp_second_index   = rsp_second_idx_ff;
   assign rsp_best_error     = rsp_best_err_ff;
   assign rsp_second_error   = rsp_second_err_ff;
   assign rsp_is_transparent = rsp_transp_ff;

   // ---------------- assertions ----------------
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN || state_ff == ST_FINISH) |-> best_err_ff <= second_err_ff)
      else $error("best error above second error");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(v0_ff || dstat.busy))
      else $error("distance pipeline busy while idle");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> issue_ff < scan_count)
      else $error("scan address past palette size");

   a_transp_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_transparent) |->
         (rsp_best_error == ERR_SAT && rsp_second_error == ERR_SAT))
      else $error("transparent response carries an error value");

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the two-nearest palette color search.
`default_nettype none
module tb;
   import pns_pkg::*;

   // Store depth of the instance; an 8-bit entry index can never reach past it.
   localparam int N_ENTRIES       = DEFAULT_MAX_ENTRIES;
   // Cycles with no handshake on either channel before the run is declared hung.
   // The limit covers a full scan plus the longest sender gap and receiver stall.
   localparam int STALL_LIMIT     = 3000;
   // Quiet time before a register write: a load may still be in flight.
   localparam int SETTLE_CYCLES   = 16;
   // Quiet time after the last response, longer than the slowest query.
   localparam int TAIL_CYCLES     = 300;
   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 62;
   // Register index past the end of the list; the block must ignore it.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // One response, packed so fixed answers can be typed as a concatenation.
   typedef struct packed {
      logic [OUT_IDX_W-1:0] best_index;
      logic [OUT_IDX_W-1:0] second_index;
      logic [ERR_W-1:0]     best_error;
      logic [ERR_W-1:0]     second_error;
      logic                 is_transparent;
   } match_type;

   // Answers that can be read straight off the spec.
   localparam match_type TRANSPARENT_RSP = {8'd0, 8'd0, ERR_SAT, ERR_SAT, 1'b1};
   localparam match_type NONE_FOUND_RSP  = {8'd0, 8'd0, ERR_SAT, ERR_SAT, 1'b0};
   // Pixel identical to entry 0, and entry 0 is the only one scanned.
   localparam match_type EXACT_HIT_RSP   = {8'd0, 8'd0, 16'd0, ERR_SAT, 1'b0};

   // One row of the directed table: an optional register write, done once the
   // block is idle, followed by one request.
   typedef struct {
      bit                   csr_on;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [WEIGHT_W-1:0]  csr_val;
      logic                 op;
      logic [7:0]           idx;
      logic [CHAN_W-1:0]    r, g, b, a;
      bit                   pinned;   // use want instead of the predictor
      match_type            want;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic              req_operation   = OP_LOAD;
   logic [7:0]        req_entry_index = '0;
   logic [CHAN_W-1:0] req_red         = '0;
   logic [CHAN_W-1:0] req_green       = '0;
   logic [CHAN_W-1:0] req_blue        = '0;
   logic [CHAN_W-1:0] req_alpha       = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_IDX_W-1:0] rsp_best_index;
   logic [OUT_IDX_W-1:0] rsp_second_index;
   logic [ERR_W-1:0]     rsp_best_error;
   logic [ERR_W-1:0]     rsp_second_error;
   logic                 rsp_is_transparent;

   // Shadow copies of the palette and of the registers, kept in step with
   // every accepted load and every register write.
   logic [WORD_W-1:0]   palette_copy [N_ENTRIES];
   logic [WEIGHT_W-1:0] w_red   = RST_WEIGHT_RED;
   logic [WEIGHT_W-1:0] w_green = RST_WEIGHT_GREEN;
   logic [WEIGHT_W-1:0] w_blue  = RST_WEIGHT_BLUE;
   logic [WEIGHT_W-1:0] w_alpha = RST_WEIGHT_ALPHA;
   logic                alpha_on = 1'b0;
   logic [THR_W-1:0]    thr_copy  = RST_ALPHA_THRESH;
   logic [SIZE_W-1:0]   size_copy = RST_PALETTE_SIZE;

   // Answers owed by the block, oldest first.
   match_type pending_pairs [$];
   step_type  steps [$];

   int snd_max = 14;   // longest gap the sender draws before a request
   int rcv_max = 14;   // longest stall the receiver draws before a response
   int mismatches = 0;
   int strays = 0;
   int reports = 0;
   int loads_done = 0;
   int queries_done = 0;
   int checked = 0;
   int transp_seen = 0;
   int idle_cycles = 0;
   int settings_used = 1;
   match_type got, want;

   palette_two_nearest_search #(.MAX_ENTRIES(N_ENTRIES)) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_entry_index    (req_entry_index),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_alpha          (req_alpha),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_best_index     (rsp_best_index),
      .rsp_second_index   (rsp_second_index),
      .rsp_best_error     (rsp_best_error),
      .rsp_second_error   (rsp_second_error),
      .rsp_is_transparent (rsp_is_transparent)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] sq_gap(input logic [CHAN_W-1:0] x, input logic [CHAN_W-1:0] y);
      logic [63:0] d;
      d = (x > y) ? 64'(x - y) : 64'(y - x);
      return d * d;
   endfunction

   // Q54.10 error down to whole units, clipped to the 16-bit output.
   function automatic logic [ERR_W-1:0] floor_sat(input logic [63:0] err);
      return ((err >> FRAC_W) > 64'(ERR_SAT)) ? ERR_SAT : err[FRAC_W +: ERR_W];
   endfunction

   // Best and second-best palette entry for one pixel, from the shadow state.
   // Strict less-than against the stored (floored) error times 1024 means the
   // earlier entry keeps a tie.
   function automatic match_type nearest_pair(input logic [CHAN_W-1:0] pr,
                                              input logic [CHAN_W-1:0] pg,
                                              input logic [CHAN_W-1:0] pb,
                                              input logic [CHAN_W-1:0] pa);
      match_type         res;
      int                count;
      logic [63:0]       err;
      logic [ERR_W-1:0]  be, se;
      logic [7:0]        bi, si;
      logic [CHAN_W-1:0] ea, er, eg, eb;
      if (pa <= thr_copy) return TRANSPARENT_RSP;
      be = ERR_SAT;
      se = ERR_SAT;
      bi = '0;
      si = '0;
      count = (int'(size_copy) > N_ENTRIES) ? N_ENTRIES : int'(size_copy);
      for (int k = 0; k < count; k++) begin
         {ea, er, eg, eb} = palette_copy[k];
         err = 64'(w_red) * sq_gap(er, pr) + 64'(w_green) * sq_gap(eg, pg)
             + 64'(w_blue) * sq_gap(eb, pb);
         if (alpha_on) err = err + 64'(w_alpha) * sq_gap(ea, pa);
         if (err < (64'(be) << FRAC_W)) begin
            si = bi;
            se = be;
            bi = 8'(k);
            be = floor_sat(err);
         end else if (err < (64'(se) << FRAC_W)) begin
            si = 8'(k);
            se = floor_sat(err);
         end
      end
      // only one candidate: second mirrors best
      if (se == ERR_SAT) si = bi;
      res.best_index     = bi;
      res.second_index   = si;
      res.best_error     = be;
      res.second_error   = se;
      res.is_transparent = 1'b0;
      return res;
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight(input logic [WEIGHT_W-1:0] dflt);
      case ($urandom_range(0, 4))
         0: return 11'd0;
         1: return 11'd1024;
         2: return 11'h7FF;     // above 1.0, used unclamped
         3: return dflt;
         default: return 11'($urandom);
      endcase
   endfunction

   task automatic add_step(input bit csr_on, input logic [CSR_IDX_W-1:0] csr_idx,
                           input logic [WEIGHT_W-1:0] csr_val, input logic op,
                           input logic [7:0] idx, input logic [CHAN_W-1:0] r,
                           input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                           input logic [CHAN_W-1:0] a, input bit pinned,
                           input match_type want_in);
      step_type s;
      s.csr_on  = csr_on;
      s.csr_idx = csr_idx;
      s.csr_val = csr_val;
      s.op      = op;
      s.idx     = idx;
      s.r       = r;
      s.g       = g;
      s.b       = b;
      s.a       = a;
      s.pinned  = pinned;
      s.want    = want_in;
      steps = {steps, s};
   endtask

   // Register write; called at a falling edge, returns at the next one.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] which, input logic [WEIGHT_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = which;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (which)
         REG_WEIGHT_RED:   w_red     = value;
         REG_WEIGHT_GREEN: w_green   = value;
         REG_WEIGHT_BLUE:  w_blue    = value;
         REG_WEIGHT_ALPHA: w_alpha   = value;
         REG_USE_ALPHA:    alpha_on  = value[0];
         REG_ALPHA_THRESH: thr_copy  = value[THR_W-1:0];
         REG_PALETTE_SIZE: size_copy = value[SIZE_W-1:0];
         default: ;        // unused index, no effect
      endcase
   endtask

   // Stop sending and let the block go quiet before registers change.
   task automatic drain_requests();
      req_valid = 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One request: random gap, drive at the falling edge, hold until accepted,
   // then update the shadow palette or queue the answer owed.
   task automatic send_request(input logic op, input logic [7:0] idx,
                               input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a,
                               input bit pinned, input match_type want_in);
      int        gap;
      match_type owed;
      gap = $urandom_range(0, snd_max);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation   = op;
      req_entry_index = idx;
      req_red         = r;
      req_green       = g;
      req_blue        = b;
      req_alpha       = a;
      req_valid       = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_LOAD) begin
         palette_copy[idx] = {a, r, g, b};
         loads_done++;
      end else begin
         owed = pinned ? want_in : nearest_pair(r, g, b, a);
         pending_pairs = {pending_pairs, owed};
         queries_done++;
      end
      @(negedge clock);
   endtask

   // Receiver: draws a stall per response, holds ready low for it, then
   // waits with ready high for the next response.
   initial begin
      int stall;
      forever begin
         stall = $urandom_range(0, rcv_max);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Response checker: every accepted response against the oldest answer owed.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         got = {rsp_best_index, rsp_second_index, rsp_best_error, rsp_second_error,
                rsp_is_transparent};
         if (pending_pairs.size() == 0) begin
            strays++;
            reports++;
            if (reports <= 10)
               $display("%0t: response with none owed: best %0d/%0d second %0d/%0d transp %0b",
                        $time, got.best_index, got.best_error, got.second_index,
                        got.second_error, got.is_transparent);
         end else begin
            want = pending_pairs.pop_front();
            checked++;
            if (want.is_transparent) transp_seen++;
            if (got.best_index !== want.best_index || got.second_index !== want.second_index ||
                got.best_error !== want.best_error || got.second_error !== want.second_error ||
                got.is_transparent !== want.is_transparent) begin
               mismatches++;
               reports++;
               if (reports <= 10) begin
                  $display("%0t: mismatch exp best %0d/%0d second %0d/%0d transp %0b",
                           $time, want.best_index, want.best_error, want.second_index,
                           want.second_error, want.is_transparent);
                  $display("%0t:          got best %0d/%0d second %0d/%0d transp %0b",
                           $time, got.best_index, got.best_error, got.second_index,
                           got.second_error, got.is_transparent);
               end
            end
         end
      end
   end

   // Watchdog: any handshake resets the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles, %0d answers still owed",
                  $time, STALL_LIMIT, pending_pairs.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int                phase_sizes [NUM_PHASES] = '{2, 8, 1, 256, 16, 511, 3, 300, 0, 5, 32, 4};
      int                cnt;
      logic              op;
      logic [7:0]        idx;
      logic [CHAN_W-1:0] r, g, b, a;
      logic [WORD_W-1:0] src;
      logic [THR_W-1:0]  thr;

      // Directed table. Only entries 0 to 3 and 255 get loaded here, and every
      // non-transparent query scans at most the first four; the rest of the store
      // is filled before the random part.
      // transparent right after reset, then exactly at the default threshold
      add_step(0, REG_UNUSED, '0, OP_QUERY, 8'h00, 8'h12, 8'h34, 8'h56, 8'h00, 1, TRANSPARENT_RSP);
      add_step(0, REG_UNUSED, '0, OP_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd15, 1, TRANSPARENT_RSP);
      // empty scan: nothing found
      add_step(1, REG_PALETTE_SIZE, 11'd0, OP_QUERY, 8'h00, 8'h80, 8'h80, 8'h80, 8'd16, 1,
               NONE_FOUND_RSP);
      add_step(0, REG_UNUSED, '0, OP_LOAD, 8'd0,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, '0);
      add_step(0, REG_UNUSED, '0, OP_LOAD, 8'd1,   8'h00, 8'h00, 8'h00, 8'h00, 0, '0);
      add_step(0, REG_UNUSED, '0, OP_LOAD, 8'd2,   8'h55, 8'hAA, 8'h0F, 8'hF0, 0, '0);
      // same color as entry 1: an exact tie
      add_step(0, REG_UNUSED, '0, OP_LOAD, 8'd3,   8'h00, 8'h00, 8'h00, 8'h00, 0, '0);
      add_step(0, REG_UNUSED, '0, OP_LOAD, 8'd255, 8'hAA, 8'h55, 8'hF0, 8'h0F, 0, '0);
      // single entry, exact hit, no second candidate
      add_step(1, REG_PALETTE_SIZE, 11'd1, OP_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1,
               EXACT_HIT_RSP);
      add_step(1, REG_PALETTE_SIZE, 11'd4, OP_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0, '0);
      add_step(0, REG_UNUSED, '0, OP_QUERY, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 0, '0);
      add_step(1, REG_USE_ALPHA, 11'd1, OP_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h10, 0, '0);
      add_step(1, REG_WEIGHT_ALPHA, 11'h7FF, OP_QUERY, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'h20, 0, '0);
      add_step(1, REG_WEIGHT_RED, 11'd0, OP_QUERY, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 0, '0);
      add_step(1, REG_WEIGHT_GREEN, 11'd1024, OP_QUERY, 8'h00, 8'h60, 8'h60, 8'h60, 8'h60, 0, '0);
      add_step(1, REG_WEIGHT_BLUE, 11'h7FF, OP_QUERY, 8'h00, 8'h0F, 8'hF0, 8'h0F, 8'hF0, 0, '0);
      // threshold extremes: opaque pixel at 255, zero alpha at 0
      add_step(1, REG_ALPHA_THRESH, 11'd255, OP_QUERY, 8'h00, 8'h01, 8'h02, 8'h03, 8'hFF, 1,
               TRANSPARENT_RSP);
      add_step(1, REG_ALPHA_THRESH, 11'd0, OP_QUERY, 8'h00, 8'h01, 8'h02, 8'h03, 8'h00, 1,
               TRANSPARENT_RSP);
      add_step(0, REG_UNUSED, '0, OP_QUERY, 8'h00, 8'h01, 8'h02, 8'h03, 8'h01, 0, '0);
      add_step(1, REG_WEIGHT_RED, 11'h7FF, OP_QUERY, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 0, '0);
      add_step(1, REG_WEIGHT_GREEN, 11'h7FF, OP_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0, '0);
      // every error saturates: nothing found
      add_step(1, REG_PALETTE_SIZE, 11'd1, OP_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1,
               NONE_FOUND_RSP);
      // write to the index past the list must change nothing
      add_step(1, REG_UNUSED, 11'h7FF, OP_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1,
               EXACT_HIT_RSP);

      // hold reset, then release it on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (steps[i]) begin
         if (steps[i].csr_on) begin
            drain_requests();
            settings_used++;
            write_reg(steps[i].csr_idx, steps[i].csr_val);
         end
         send_request(steps[i].op, steps[i].idx, steps[i].r, steps[i].g, steps[i].b,
                      steps[i].a, steps[i].pinned, steps[i].want);
      end

      // Fill the whole store so any scan length reads only written entries.
      for (int k = 0; k < N_ENTRIES; k++) begin
         src = $urandom;
         send_request(OP_LOAD, 8'(k), src[23:16], src[15:8], src[7:0], src[31:24], 0, '0);
      end

      // Random phases. Each starts from an idle block (the sender waits for
      // every owed answer), then rewrites all registers. Most phases use short
      // scans; a few use the full store or an oversized count.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_requests();
         settings_used++;
         write_reg(REG_WEIGHT_RED,   pick_weight(RST_WEIGHT_RED));
         write_reg(REG_WEIGHT_GREEN, pick_weight(RST_WEIGHT_GREEN));
         write_reg(REG_WEIGHT_BLUE,  pick_weight(RST_WEIGHT_BLUE));
         write_reg(REG_WEIGHT_ALPHA, pick_weight(RST_WEIGHT_ALPHA));
         write_reg(REG_USE_ALPHA,    11'($urandom_range(0, 1)));
         case ($urandom_range(0, 2))
            0: thr = 8'd0;
            1: thr = RST_ALPHA_THRESH;
            default: thr = 8'($urandom_range(0, 127));
         endcase
         if (ph == 3) thr = 8'd255;   // one phase where every pixel is transparent
         write_reg(REG_ALPHA_THRESH, 11'(thr));
         write_reg(REG_PALETTE_SIZE, 11'(phase_sizes[ph]));
         // every fourth phase runs with no gaps and no stalls
         snd_max = (ph % 4 == 1) ? 0 : 14;
         rcv_max = (ph % 4 == 1) ? 0 : 14;
         cnt = (phase_sizes[ph] > N_ENTRIES) ? N_ENTRIES : phase_sizes[ph];

         repeat (ITEMS_PER_PHASE) begin
            idx = 8'($urandom);
            if ($urandom_range(0, 9) < 3) begin
               op = OP_LOAD;
               // sometimes copy an existing entry to create ties
               if ($urandom_range(0, 4) == 0) src = palette_copy[$urandom_range(0, N_ENTRIES - 1)];
               else src = $urandom;
               {a, r, g, b} = src;
            end else begin
               op = OP_QUERY;
               if (cnt != 0 && $urandom_range(0, 1) == 1) begin
                  // near a scanned entry: small or zero errors, close runners-up
                  {a, r, g, b} = palette_copy[$urandom_range(0, cnt - 1)];
                  r = r + 8'($urandom_range(0, 6)) - 8'd3;
                  g = g + 8'($urandom_range(0, 6)) - 8'd3;
                  b = b + 8'($urandom_range(0, 6)) - 8'd3;
               end else begin
                  {a, r, g, b} = $urandom;
               end
               // mostly opaque enough to search, sometimes at or under the threshold
               case ($urandom_range(0, 9))
                  0: a = 8'($urandom_range(0, thr_copy));
                  1: a = thr_copy;
                  2: if (thr_copy != 8'd255) a = thr_copy + 8'd1;
                  default: if (a <= thr_copy && thr_copy != 8'd255)
                              a = 8'($urandom_range(thr_copy + 1, 255));
               endcase
            end
            send_request(op, idx, r, g, b, a, 0, '0);
         end
      end

      // Wind down: wait for every owed answer, then watch for extra responses.
      req_valid = 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d loads and %0d queries across %0d register settings.",
               loads_done, queries_done, settings_used);
      $display("Checked %0d responses (%0d transparent): %0d mismatches, %0d unexpected.",
               checked, transp_seen, mismatches, strays);
      if (mismatches == 0 && strays == 0 && pending_pairs.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
